// ===== src/pkm_pkg.sv =====
// ----------------------------------------------------------------------------
// pkm_pkg
// Shared constants, codes and types of the per-sensor min/max/mean block.
// ----------------------------------------------------------------------------
package pkm_pkg;

  // Sizing
  localparam int NUM_SENSORS = 128;
  localparam int COUNT_BITS  = 20;
  localparam int ADDR_W      = $clog2(NUM_SENSORS);

  // Fixed field widths
  localparam int ID_W      = 7;
  localparam int TAG_W     = 40;
  localparam int VAL_W     = 24;
  localparam int OUT_CNT_W = 20;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 2;

  // Accumulator and divider widths
  localparam int SUM_W = VAL_W + COUNT_BITS;   // holds full count of extreme values
  localparam int NUM_W = SUM_W + 1;            // 2*|sum| + count
  localparam int DIV_W = COUNT_BITS + 1;       // 2*count
  localparam int QB    = VAL_W;                // quotient bits, mean fits in a value

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  // Operation codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_RANGE  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_BAD_ID = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_REPORT = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LIMIT = 2'd1;

  localparam logic signed [VAL_W-1:0] LOW_LIMIT_RST  = 24'sd100;
  localparam logic signed [VAL_W-1:0] HIGH_LIMIT_RST = 24'sd3000000;

  // One channel's statistics as kept in memory
  typedef struct packed {
    logic signed [VAL_W-1:0]  peak_val;
    logic [TAG_W-1:0]         max_time;
    logic signed [VAL_W-1:0]  trough_val;
    logic [TAG_W-1:0]         min_time;
    logic signed [SUM_W-1:0]  sum;
    logic [COUNT_BITS-1:0]    count;
  } pkm_entry_t;

  localparam int ENTRY_W = $bits(pkm_entry_t);

  // One result
  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic                     has_data;
    logic signed [VAL_W-1:0]  peak_val;
    logic [TAG_W-1:0]         max_time;
    logic signed [VAL_W-1:0]  trough_val;
    logic [TAG_W-1:0]         min_time;
    logic signed [VAL_W-1:0]  avg_val;
    logic [OUT_CNT_W-1:0]     sample_count;
  } pkm_res_t;

endpackage

// ===== src/pkm_if.sv =====
// ----------------------------------------------------------------------------
// pkm_if
// Valid/ready channels: sample/report requests, results and config writes.
// ----------------------------------------------------------------------------
interface pkm_req_if import pkm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    op;
  logic [ID_W-1:0]         sensor_id;
  logic [TAG_W-1:0]        time_tag;
  logic signed [VAL_W-1:0] sample_value;

  modport source (output valid, op, sensor_id, time_tag, sample_value, input ready);
  modport sink   (input valid, op, sensor_id, time_tag, sample_value, output ready);
endinterface

interface pkm_rsp_if import pkm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic                    has_data;
  logic signed [VAL_W-1:0] peak_val;
  logic [TAG_W-1:0]        max_time;
  logic signed [VAL_W-1:0] trough_val;
  logic [TAG_W-1:0]        min_time;
  logic signed [VAL_W-1:0] avg_val;
  logic [OUT_CNT_W-1:0]    sample_count;

  modport source (output valid, status, has_data, peak_val, max_time, trough_val,
                  min_time, avg_val, sample_count, input ready);
  modport sink   (input valid, status, has_data, peak_val, max_time, trough_val,
                  min_time, avg_val, sample_count, output ready);
endinterface

interface pkm_cfg_if import pkm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [VAL_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/pkm_ram.sv =====
// ----------------------------------------------------------------------------
// pkm_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module pkm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/pkm_div.sv =====
// ----------------------------------------------------------------------------
// pkm_div
// Rounded signed mean: (2|sum| + count) / (2 count), one quotient bit a cycle.
// ----------------------------------------------------------------------------
module pkm_div import pkm_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [SUM_W-1:0] sum_i,
  input  logic [COUNT_BITS-1:0]   count_i,
  output logic                    done_o,
  output logic signed [VAL_W-1:0] mean_o
);

  localparam int CTR_W = $clog2(QB);

  logic                  busy_q, done_q, neg_q;
  logic [CTR_W-1:0]      ctr_q;
  logic [DIV_W-1:0]      rem_q, dvs_q;
  logic [QB-1:0]         shf_q, quo_q;
  logic                  neg;
  logic [SUM_W-1:0]      mag;
  logic [NUM_W-1:0]      num;
  logic [DIV_W:0]        trial;
  logic                  take;

  // Operand set-up: magnitude, doubled, plus count for the half-up rounding
  assign neg = sum_i[SUM_W-1];
  assign mag = neg ? (~sum_i + 1'b1) : sum_i;
  assign num = {mag, 1'b0} + NUM_W'(count_i);

  // Restoring step; the upper part of the dividend is already below the divisor
  assign trial = {rem_q, shf_q[QB-1]};
  assign take  = (trial >= {1'b0, dvs_q});

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      ctr_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        ctr_q  <= '0;
      end else if (busy_q) begin
        ctr_q <= ctr_q + 1'b1;
        if (ctr_q == CTR_W'(QB - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= neg;
      dvs_q <= {count_i, 1'b0};
      rem_q <= num[NUM_W-1:QB];
      shf_q <= num[QB-1:0];
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= take ? DIV_W'(trial - {1'b0, dvs_q}) : trial[DIV_W-1:0];
      shf_q <= {shf_q[QB-2:0], 1'b0};
      quo_q <= {quo_q[QB-2:0], take};
    end
  end

  assign done_o = done_q;
  assign mean_o = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule

// ===== src/per_sensor_min_max_mean_core.sv =====
// ----------------------------------------------------------------------------
// per_sensor_min_max_mean_core
// Running max/min (with time tags), sum and count per sensor channel, with
// reports giving the mean rounded to the nearest integer.
// ----------------------------------------------------------------------------
//  channel | dir | handshake       | payload
//  cfg_i   | in  | valid / ready   | index, data (low/high limit)
//  req_i   | in  | valid / ready   | op, sensor_id, time_tag, sample_value
//  rsp_o   | out | valid / ready   | status, has_data, extremes, mean, count
//
//  A sample or a rejected request goes through the read, evaluate and finish
//  states to the result register; a report with data also waits in the divide
//  state for the bit-serial divider. Requests are handled one at a time; the
//  memory read, update and write-back of one request finish before the next is
//  read. Reset clears the channel valid bits and restores the limits; the
//  memory needs no clearing. A held result does not block acceptance of the
//  next request, only its own completion.
// ----------------------------------------------------------------------------
module per_sensor_min_max_mean_core import pkm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  pkm_cfg_if.sink    cfg_i,
  pkm_req_if.sink    req_i,
  pkm_rsp_if.source  rsp_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]              state_q, state_d;
  logic signed [VAL_W-1:0] low_q, high_q;
  logic [NUM_SENSORS-1:0]  valid_q, valid_d;

  logic                    op_q;
  logic [ID_W-1:0]         id_q;
  logic [TAG_W-1:0]        tag_q;
  logic signed [VAL_W-1:0] val_q;

  pkm_res_t                res_q, res_d, out_q;
  logic                    out_valid_q, out_valid_d;

  logic                    accept, cfg_wr, out_load;
  logic [ADDR_W-1:0]       addr;
  pkm_entry_t              cur, upd;
  logic                    we, hit, id_ok, in_range, div_start, div_done;
  logic signed [VAL_W-1:0] div_mean;

  assign accept = req_i.valid && req_i.ready;
  assign cfg_wr = cfg_i.valid && cfg_i.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= LOW_LIMIT_RST;
      high_q <= HIGH_LIMIT_RST;
    end else if (cfg_wr) begin
      case (cfg_i.index)
        CFG_LOW_LIMIT:  low_q  <= cfg_i.data;
        CFG_HIGH_LIMIT: high_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Request capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= req_i.op;
      id_q  <= req_i.sensor_id;
      tag_q <= req_i.time_tag;
      val_q <= req_i.sample_value;
    end
  end

  // Channel statistics memory; read issued with the request
  pkm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_SENSORS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (addr),
    .wdata_i (upd),
    .re_i    (accept),
    .raddr_i (ADDR_W'(req_i.sensor_id)),
    .rdata_o (cur)
  );

  pkm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .sum_i   (cur.sum),
    .count_i (cur.count),
    .done_o  (div_done),
    .mean_o  (div_mean)
  );

  // Request decode
  assign addr     = ADDR_W'(id_q);
  assign id_ok    = (id_q != '0) && (int'(id_q) < NUM_SENSORS);
  assign hit      = valid_q[addr];
  assign in_range = (val_q >= low_q) && (val_q <= high_q);

  // Entry update for an accepted sample
  always_comb begin
    upd = cur;
    if (!hit) begin
      upd.peak_val   = val_q;
      upd.max_time   = tag_q;
      upd.trough_val = val_q;
      upd.min_time   = tag_q;
      upd.sum        = {{COUNT_BITS{val_q[VAL_W-1]}}, val_q};
      upd.count      = COUNT_BITS'(1);
    end else begin
      if (val_q > cur.peak_val) begin
        upd.peak_val = val_q;
        upd.max_time = tag_q;
      end
      if (val_q < cur.trough_val) begin
        upd.trough_val = val_q;
        upd.min_time   = tag_q;
      end
      if (cur.count < CNT_MAX) begin
        upd.sum   = cur.sum + {{COUNT_BITS{val_q[VAL_W-1]}}, val_q};
        upd.count = cur.count + 1'b1;
      end
    end
  end

  // Sequencer
  assign out_load = (state_q == S_FIN) && (!out_valid_q || rsp_o.ready);

  always_comb begin
    state_d   = state_q;
    res_d     = res_q;
    valid_d   = valid_q;
    we        = 1'b0;
    div_start = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_RD;
      end
      S_RD: begin
        state_d = S_EVAL;
      end
      S_EVAL: begin
        res_d   = '0;
        state_d = S_FIN;
        if (!id_ok) begin
          res_d.status = STAT_BAD_ID;
        end else if (op_q == OP_REPORT) begin
          res_d.status = STAT_REPORT;
          if (hit) begin
            res_d.has_data     = 1'b1;
            res_d.peak_val     = cur.peak_val;
            res_d.max_time     = cur.max_time;
            res_d.trough_val   = cur.trough_val;
            res_d.min_time     = cur.min_time;
            res_d.sample_count = OUT_CNT_W'(cur.count);
            div_start          = 1'b1;
            state_d            = S_DIV;
          end
        end else if (!in_range) begin
          res_d.status = STAT_RANGE;
        end else begin
          res_d.status  = STAT_OK;
          we            = 1'b1;
          valid_d[addr] = 1'b1;
        end
      end
      S_DIV: begin
        if (div_done) begin
          res_d.avg_val = div_mean;
          state_d       = S_FIN;
        end
      end
      S_FIN: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q && !rsp_o.ready;
    if (out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_q <= res_q;
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_q.status;
  assign rsp_o.has_data     = out_q.has_data;
  assign rsp_o.peak_val     = out_q.peak_val;
  assign rsp_o.max_time     = out_q.max_time;
  assign rsp_o.trough_val   = out_q.trough_val;
  assign rsp_o.min_time     = out_q.min_time;
  assign rsp_o.avg_val      = out_q.avg_val;
  assign rsp_o.sample_count = out_q.sample_count;

`ifndef SYNTHESIS
  // An accepted request always reaches the memory read stage next
  a_accept_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_RD))
    else $error("accepted request did not enter read stage");

  // Memory writes only come from evaluation of a sample with a valid id
  a_we_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q == S_EVAL) && id_ok && (op_q == OP_SAMPLE))
    else $error("memory written outside sample evaluation");

  // The divider finishes only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider result with no report pending");

  // A written channel is marked valid on the following cycle
  a_valid_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |=> valid_q[$past(addr)])
    else $error("channel valid bit not set after write");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the per-sensor min/max/mean core. Requests are sent
// through the valid/ready channels under varying idle and stall patterns; a
// behavioural copy of the channel statistics predicts every result, which is
// checked field by field in arrival order. Limits are reprogrammed between
// phases while the core is idle.
// ----------------------------------------------------------------------------
module tb_top;
  import pkm_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_GAP        = 40;
  localparam int DRAIN_CYCLES   = 40;

  logic clk_i;
  logic rst_ni;

  pkm_cfg_if cfg_if ();
  pkm_req_if req_if ();
  pkm_rsp_if rsp_if ();

  per_sensor_min_max_mean_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Behavioural copy of the limits and the channel statistics
  logic signed [VAL_W-1:0] low_lim;
  logic signed [VAL_W-1:0] high_lim;
  logic                    stat_seen  [NUM_SENSORS];
  logic signed [VAL_W-1:0] stat_max   [NUM_SENSORS];
  logic [TAG_W-1:0]        stat_max_t [NUM_SENSORS];
  logic signed [VAL_W-1:0] stat_min   [NUM_SENSORS];
  logic [TAG_W-1:0]        stat_min_t [NUM_SENSORS];
  logic signed [SUM_W-1:0] stat_sum   [NUM_SENSORS];
  logic [COUNT_BITS-1:0]   stat_count [NUM_SENSORS];

  pkm_res_t                pending_results[$];
  logic signed [VAL_W-1:0] recent_values[$];

  int unsigned mismatch_count;
  int unsigned send_idle_pct;
  int unsigned rsp_stall_pct;
  int unsigned rsp_hold_left;
  int unsigned quiet_cycles;

  // Clock and reset
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor: applies one request to the statistics, returns the result
  // ---------------------------------------------------------------------------
  function automatic pkm_res_t apply_request(logic op, logic [ID_W-1:0] id,
                                             logic [TAG_W-1:0] tag,
                                             logic signed [VAL_W-1:0] val);
    pkm_res_t res;
    longint   total;
    longint   mag;
    longint   cnt;
    longint   quot;
    res = '0;
    if (id == '0 || int'(id) >= NUM_SENSORS) begin
      res.status = STAT_BAD_ID;
    end else if (op == OP_REPORT) begin
      res.status = STAT_REPORT;
      if (stat_seen[id]) begin
        total = longint'(stat_sum[id]);
        cnt   = longint'(stat_count[id]);
        mag   = (total < 0) ? -total : total;
        // rounded half away from zero
        quot  = (2 * mag + cnt) / (2 * cnt);
        res.has_data     = 1'b1;
        res.peak_val     = stat_max[id];
        res.max_time     = stat_max_t[id];
        res.trough_val   = stat_min[id];
        res.min_time     = stat_min_t[id];
        res.avg_val      = VAL_W'((total < 0) ? -quot : quot);
        res.sample_count = OUT_CNT_W'(stat_count[id]);
      end
    end else if (val < low_lim || val > high_lim) begin
      res.status = STAT_RANGE;
    end else begin
      res.status = STAT_OK;
      if (!stat_seen[id]) begin
        stat_seen[id]  = 1'b1;
        stat_max[id]   = val;
        stat_max_t[id] = tag;
        stat_min[id]   = val;
        stat_min_t[id] = tag;
        stat_sum[id]   = SUM_W'(val);
        stat_count[id] = COUNT_BITS'(1);
      end else begin
        // ties keep the earlier tag
        if (val > stat_max[id]) begin
          stat_max[id]   = val;
          stat_max_t[id] = tag;
        end
        if (val < stat_min[id]) begin
          stat_min[id]   = val;
          stat_min_t[id] = tag;
        end
        // sum and count freeze once the count saturates
        if (stat_count[id] != CNT_MAX) begin
          stat_sum[id]   = stat_sum[id] + val;
          stat_count[id] = stat_count[id] + 1'b1;
        end
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers; all are entered just after a rising edge
  // ---------------------------------------------------------------------------
  task automatic send_request(logic op, logic [ID_W-1:0] id, logic [TAG_W-1:0] tag,
                              logic signed [VAL_W-1:0] val);
    int unsigned gap;
    pkm_res_t    expected;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.op           <= op;
    req_if.sensor_id    <= id;
    req_if.time_tag     <= tag;
    req_if.sample_value <= val;
    do @(posedge clk_i); while (!req_if.ready);
    expected        = apply_request(op, id, tag, val);
    pending_results = {pending_results, expected};
    if (op == OP_SAMPLE) begin
      recent_values = {recent_values, val};
      if (recent_values.size() > 16) void'(recent_values.pop_front());
    end
  endtask

  task automatic release_request();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [CFG_IDX_W-1:0] idx, logic signed [VAL_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    if (idx == CFG_LOW_LIMIT) low_lim = value;
    else if (idx == CFG_HIGH_LIMIT) high_lim = value;
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Limits only change while nothing is in flight
  task automatic set_limits(logic signed [VAL_W-1:0] lo, logic signed [VAL_W-1:0] hi);
    release_request();
    wait_drained();
    write_limit(CFG_LOW_LIMIT, lo);
    write_limit(CFG_HIGH_LIMIT, hi);
  endtask

  function automatic logic [ID_W-1:0] pick_sensor();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 3) return '0;
    if (r < 70) return ID_W'($urandom_range(6, 1));
    return ID_W'($urandom_range(127, 1));
  endfunction

  function automatic logic [TAG_W-1:0] pick_tag();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    return {8'($urandom_range(255)), 32'($urandom)};
  endfunction

  // Mostly in range, with limit values, near misses, repeats and noise
  function automatic logic signed [VAL_W-1:0] pick_value();
    int          lo;
    int          hi;
    int          v;
    int unsigned r;
    lo = int'(low_lim);
    hi = int'(high_lim);
    r  = $urandom_range(99);
    if (lo > hi || r < 8) v = int'($urandom);
    else if (r < 16) v = $urandom_range(1) ? lo : hi;
    else if (r < 24) v = $urandom_range(1) ? lo - 1 : hi + 1;
    else if (r < 36 && recent_values.size() != 0)
      v = int'(recent_values[$urandom_range(recent_values.size() - 1)]);
    else v = lo + int'($urandom_range(hi - lo));
    return VAL_W'(v);
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: ready pattern, checking, watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rsp_hold_left > 0) begin
      rsp_if.ready <= 1'b0;
      rsp_hold_left--;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
  endtask

  task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk_i) begin : check_results
    pkm_res_t got;
    pkm_res_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got.status       = rsp_if.status;
      got.has_data     = rsp_if.has_data;
      got.peak_val     = rsp_if.peak_val;
      got.max_time     = rsp_if.max_time;
      got.trough_val   = rsp_if.trough_val;
      got.min_time     = rsp_if.min_time;
      got.avg_val      = rsp_if.avg_val;
      got.sample_count = rsp_if.sample_count;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 64'(got.status), '0);
      end else begin
        want = pending_results.pop_front();
        check_field("status",       got.status,       want.status);
        check_field("has_data",     got.has_data,     want.has_data);
        check_field("peak_val",     got.peak_val,     want.peak_val);
        check_field("max_time",     got.max_time,     want.max_time);
        check_field("trough_val",   got.trough_val,   want.trough_val);
        check_field("min_time",     got.min_time,     want.min_time);
        check_field("avg_val",      got.avg_val,      want.avg_val);
        check_field("sample_count", got.sample_count, want.sample_count);
      end
    end
  end

  // Ends the run when no transfer happens on any channel for too long
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired, %0d results outstanding", pending_results.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset limits: empty channel, bad id, limit edges and ties
  task automatic test_reset_limits();
    send_request(OP_REPORT, 7'd5,   '0,       '0);
    send_request(OP_SAMPLE, 7'd0,   40'd3,    24'sd500);
    send_request(OP_REPORT, 7'd0,   40'd4,    '0);
    send_request(OP_SAMPLE, 7'd127, '1,       24'sd100);
    send_request(OP_SAMPLE, 7'd127, 40'd5,    24'sd99);
    send_request(OP_SAMPLE, 7'd127, '0,       24'sd3000000);
    send_request(OP_SAMPLE, 7'd127, 40'd6,    24'sd3000001);
    send_request(OP_SAMPLE, 7'd127, 40'd7,    24'sd3000000);
    send_request(OP_SAMPLE, 7'd127, 40'd9,    24'sd100);
    send_request(OP_REPORT, 7'd127, '0,       '0);
  endtask

  // Widest limits: full-scale values and a mean that rounds away from zero
  task automatic test_full_scale();
    set_limits(24'sh800000, 24'sh7fffff);
    send_request(OP_SAMPLE, 7'd1,  40'd1, 24'sh800000);
    send_request(OP_SAMPLE, 7'd1,  40'd2, 24'sh7fffff);
    send_request(OP_REPORT, 7'd1,  '0,    '0);
    send_request(OP_SAMPLE, 7'd64, '1,    24'sh800000);
    send_request(OP_SAMPLE, 7'd64, 40'd8, 24'sh800000);
    send_request(OP_REPORT, 7'd64, '0,    '0);
  endtask

  // Half-way means, positive and negative
  task automatic test_rounding();
    set_limits(-24'sd100, 24'sd100);
    send_request(OP_SAMPLE, 7'd2, 40'd10, 24'sd1);
    send_request(OP_SAMPLE, 7'd2, 40'd11, 24'sd2);
    send_request(OP_REPORT, 7'd2, '0,     '0);
    send_request(OP_SAMPLE, 7'd3, 40'd12, -24'sd1);
    send_request(OP_SAMPLE, 7'd3, 40'd13, -24'sd2);
    send_request(OP_REPORT, 7'd3, '0,     '0);
  endtask

  // Low limit above high limit rejects everything
  task automatic test_crossed_limits();
    set_limits(24'sd1, 24'sd0);
    send_request(OP_SAMPLE, 7'd4, 40'd20, 24'sd0);
    send_request(OP_SAMPLE, 7'd4, 40'd21, 24'sd1);
    send_request(OP_REPORT, 7'd4, '0,     '0);
  endtask

  task automatic run_traffic(int unsigned n_items, int unsigned idle_pct,
                             int unsigned stall_pct, bit pause_midway);
    int unsigned k;
    logic        op;
    send_idle_pct = idle_pct;
    rsp_stall_pct = stall_pct;
    for (k = 0; k < n_items; k++) begin
      // sender pauses until every outstanding result is back
      if (pause_midway && k == n_items / 2) begin
        release_request();
        wait_drained();
      end
      op = ($urandom_range(99) < 20) ? OP_REPORT : OP_SAMPLE;
      send_request(op, pick_sensor(), pick_tag(), pick_value());
    end
    release_request();
  endtask

  // Long receiver hold while requests keep coming, so the input stalls
  task automatic test_backpressure();
    int unsigned k;
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    @(negedge clk_i);
    rsp_hold_left = 400;
    @(posedge clk_i);
    for (k = 0; k < 60; k++)
      send_request(($urandom_range(99) < 20) ? OP_REPORT : OP_SAMPLE,
                   pick_sensor(), pick_tag(), pick_value());
    release_request();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni              = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = CFG_LOW_LIMIT;
    cfg_if.data         = '0;
    req_if.valid        = 1'b0;
    req_if.op           = OP_SAMPLE;
    req_if.sensor_id    = '0;
    req_if.time_tag     = '0;
    req_if.sample_value = '0;
    rsp_if.ready        = 1'b0;
    low_lim             = LOW_LIMIT_RST;
    high_lim            = HIGH_LIMIT_RST;
    mismatch_count      = 0;
    send_idle_pct       = 0;
    rsp_stall_pct       = 0;
    rsp_hold_left       = 0;
    quiet_cycles        = 0;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      stat_seen[i] = 1'b0;
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_limits();
    test_full_scale();
    test_rounding();
    test_crossed_limits();

    set_limits(LOW_LIMIT_RST, HIGH_LIMIT_RST);
    run_traffic(450, 0, 0, 1'b0);
    set_limits(24'sh800000, 24'sh7fffff);
    run_traffic(450, 54, 0, 1'b0);
    set_limits(-24'sd1000, 24'sd1000);
    run_traffic(450, 0, 54, 1'b0);
    set_limits(24'sh800000, -24'sd1);
    run_traffic(450, 18, 18, 1'b1);
    test_backpressure();
    set_limits(24'sd50, -24'sd50);
    run_traffic(40, 18, 18, 1'b0);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
